>>> rtl/core/days_between_dates_defines.svh
// Assertion macros used by the checker module of the day count block.
// Depends on nothing; included by name where assertions are written.
`ifndef DAYS_BETWEEN_DATES_DEFINES_SVH
`define DAYS_BETWEEN_DATES_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DBD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define DBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dbd_pkg.sv
// Package for the day count block: field widths, limits and the month table.
// Depends on nothing; used by days_between_dates and dbd_checker.
package dbd_pkg;

  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int CountW = 22;
  localparam int TailW  = 9;

  localparam int MAX_YEAR_DEF = 9999;

  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

  localparam logic [TailW-1:0] DAYS_COMMON = 9'd365;
  localparam logic [TailW-1:0] DAYS_LEAP   = 9'd366;

  localparam logic [MonthW-1:0] MONTH_JAN = 4'd1;
  localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
  localparam logic [MonthW-1:0] MONTH_DEC = 4'd12;

  // Days from the first day of the month to the end of the year.
  function automatic logic [TailW-1:0] tail_of_year(input logic [MonthW-1:0] month,
                                                    input logic leap);
    logic [TailW-1:0] v;
    begin
      case (month)
        4'd1:    v = 9'd365;
        4'd2:    v = 9'd334;
        4'd3:    v = 9'd306;
        4'd4:    v = 9'd275;
        4'd5:    v = 9'd245;
        4'd6:    v = 9'd214;
        4'd7:    v = 9'd184;
        4'd8:    v = 9'd153;
        4'd9:    v = 9'd122;
        4'd10:   v = 9'd92;
        4'd11:   v = 9'd61;
        4'd12:   v = 9'd31;
        default: v = '0;
      endcase
      if (leap && (month == MONTH_JAN || month == MONTH_FEB)) begin
        v = v + 9'd1;
      end
      return v;
    end
  endfunction

endpackage

>>> rtl/core/days_between_dates.sv
// Top level of the day count block: sequencer, year sweep and result register.
// Depends on dbd_pkg.
// Sequence: an accepted valid transaction passes ST_SWEEP, ST_TAIL0, ST_TAIL1 and ST_RESULT,
// and the result strobe is registered after ST_RESULT; a rejected one goes straight to ST_RESULT.
// Throughput: one transaction at a time, set by the sweep that visits one year per cycle
// from year 0 through end_year with the accumulator and the leap counters.
// Reset clears the sequencer and sets skip_q to 1; the receiver cannot stall.
module days_between_dates #(
  parameter int MAX_YEAR = dbd_pkg::MAX_YEAR_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [dbd_pkg::YearW-1:0]   start_year_i,
  input  logic [dbd_pkg::MonthW-1:0]  start_month_i,
  input  logic [dbd_pkg::DayW-1:0]    start_day_i,
  input  logic [dbd_pkg::YearW-1:0]   end_year_i,
  input  logic [dbd_pkg::MonthW-1:0]  end_month_i,
  input  logic [dbd_pkg::DayW-1:0]    end_day_i,
  output logic                        done_o,
  output logic [dbd_pkg::CountW-1:0]  day_count_o,
  output logic                        bad_input_o
);

  localparam int AccRaw = $clog2((MAX_YEAR + 1) * 366 + 1024) + 1;
  localparam int AccW   = (AccRaw > dbd_pkg::CountW + 1) ? AccRaw : dbd_pkg::CountW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_TAIL0,
    ST_TAIL1,
    ST_RESULT
  } state_e;

  state_e                       state_q;
  logic                         skip_q;
  logic [dbd_pkg::YearW-1:0]    y0_q, y1_q, yr_q;
  logic [dbd_pkg::MonthW-1:0]   m0_q, m1_q;
  logic [dbd_pkg::DayW-1:0]     d0_q, d1_q;
  logic [1:0]                   mod4_q;
  logic [6:0]                   mod100_q;
  logic [8:0]                   mod400_q;
  logic [11:0]                  mod4000_q;
  logic                         l0_q, l1_q, bad_q, done_q;
  logic signed [AccW-1:0]       acc_q;
  logic [dbd_pkg::CountW-1:0]   count_q;

  logic                         leap;
  logic                         in_bad;
  logic [dbd_pkg::TailW-1:0]    tail0, tail1, len1;
  logic signed [AccW-1:0]       year_len;

  always_comb begin
    if (skip_q && mod4000_q == 12'd0) begin
      leap = 1'b0;
    end else if (mod400_q == 9'd0) begin
      leap = 1'b1;
    end else if (mod100_q == 7'd0) begin
      leap = 1'b0;
    end else begin
      leap = (mod4_q == 2'd0);
    end
  end

  always_comb begin
    in_bad = 1'b0;
    if (start_month_i < dbd_pkg::MONTH_JAN || start_month_i > dbd_pkg::MONTH_DEC ||
        end_month_i < dbd_pkg::MONTH_JAN || end_month_i > dbd_pkg::MONTH_DEC) begin
      in_bad = 1'b1;
    end
    if ({18'd0, start_year_i} > 32'(MAX_YEAR) || {18'd0, end_year_i} > 32'(MAX_YEAR)) begin
      in_bad = 1'b1;
    end
    if (end_year_i < start_year_i) begin
      in_bad = 1'b1;
    end
  end

  assign tail0    = dbd_pkg::tail_of_year(m0_q, l0_q);
  assign tail1    = dbd_pkg::tail_of_year(m1_q, l1_q);
  assign len1     = l1_q ? dbd_pkg::DAYS_LEAP : dbd_pkg::DAYS_COMMON;
  assign year_len = $signed(AccW'(leap ? dbd_pkg::DAYS_LEAP : dbd_pkg::DAYS_COMMON));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= 1'b1;
    end else if (cfg_we_i) begin
      skip_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      bad_q   <= 1'b0;
      count_q <= '0;
    end else begin
      done_q <= (state_q == ST_RESULT);
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            y0_q      <= start_year_i;
            m0_q      <= start_month_i;
            d0_q      <= start_day_i;
            y1_q      <= end_year_i;
            m1_q      <= end_month_i;
            d1_q      <= end_day_i;
            yr_q      <= '0;
            mod4_q    <= '0;
            mod100_q  <= '0;
            mod400_q  <= '0;
            mod4000_q <= '0;
            acc_q     <= '0;
            bad_q     <= in_bad;
            state_q   <= in_bad ? ST_RESULT : ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (yr_q == y0_q) begin
            l0_q <= leap;
          end
          if (yr_q == y1_q) begin
            l1_q    <= leap;
            state_q <= ST_TAIL0;
          end else begin
            if (yr_q > y0_q) begin
              acc_q <= acc_q + year_len;
            end
            yr_q      <= yr_q + 1'b1;
            mod4_q    <= mod4_q + 2'd1;
            mod100_q  <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
            mod400_q  <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
            mod4000_q <= (mod4000_q == 12'd3999) ? 12'd0 : mod4000_q + 12'd1;
          end
        end
        ST_TAIL0: begin
          acc_q   <= acc_q + $signed(AccW'(tail0)) - $signed(AccW'(d0_q));
          state_q <= ST_TAIL1;
        end
        ST_TAIL1: begin
          if (y0_q == y1_q) begin
            acc_q <= acc_q + $signed(AccW'(d1_q)) - $signed(AccW'(tail1));
          end else begin
            acc_q <= acc_q + $signed(AccW'(len1)) + $signed(AccW'(d1_q))
                     - $signed(AccW'(tail1));
          end
          state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          state_q <= ST_IDLE;
          if (bad_q || acc_q < 0) begin
            bad_q   <= 1'b1;
            count_q <= '0;
          end else if (acc_q > $signed(AccW'(dbd_pkg::COUNT_MAX))) begin
            count_q <= dbd_pkg::COUNT_MAX;
          end else begin
            count_q <= acc_q[dbd_pkg::CountW-1:0];
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign day_count_o = count_q;
  assign bad_input_o = bad_q;

endmodule

>>> rtl/core/dbd_checker.sv
// Port-level checker for the day count block, bound to days_between_dates.
// Depends on dbd_pkg and days_between_dates_defines.svh.
`include "days_between_dates_defines.svh"

module dbd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic [dbd_pkg::CountW-1:0]  day_count_o,
  input logic                        bad_input_o
);

  `DBD_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy,
                   "Accepted transaction did not raise busy.")
  `DBD_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o, !busy,
                   "Result strobe while still busy.")
  `DBD_ASSERT_IMPL(a_fell_done, clk_i, rst_ni, $fell(busy), done_o,
                   "Busy dropped without a result.")
  `DBD_ASSERT_NEXT(a_single_done, clk_i, rst_ni, done_o, !done_o,
                   "Result strobe lasted more than one cycle.")
  `DBD_ASSERT_IMPL(a_bad_zero, clk_i, rst_ni, done_o && bad_input_o, day_count_o == '0,
                   "Rejected transaction returned a nonzero count.")

endmodule

bind days_between_dates dbd_checker u_dbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .day_count_o (day_count_o),
  .bad_input_o (bad_input_o)
);
